### hw/rtl/gds_pkg.sv
// shared types, constants and calendar functions for the day span block
package gds_pkg;

  localparam int NUM_W  = 27;  // divider dividend and quotient width
  localparam int DEN_W  = 14;  // divider divisor and remainder width
  localparam int YEAR_W = 14;
  localparam int MON_W  = 7;
  localparam int DAY_W  = 7;
  localparam int DNUM_W = 23;  // day number since year zero
  localparam int CNT_W  = 22;

  localparam logic [DEN_W-1:0] DIV_YEAR  = DEN_W'(10000);
  localparam logic [DEN_W-1:0] DIV_MONTH = DEN_W'(100);
  localparam logic [DEN_W-1:0] DIV_CENT  = DEN_W'(100);
  localparam logic [DEN_W-1:0] DIV_QUAD  = DEN_W'(400);

  localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = {CNT_W{1'b1}};

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
    logic [DEN_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [4:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
    logic [8:0] n;
    case (m)
      7'd1:    n = 9'd0;
      7'd2:    n = 9'd31;
      7'd3:    n = 9'd59;
      7'd4:    n = 9'd90;
      7'd5:    n = 9'd120;
      7'd6:    n = 9'd151;
      7'd7:    n = 9'd181;
      7'd8:    n = 9'd212;
      7'd9:    n = 9'd243;
      7'd10:   n = 9'd273;
      7'd11:   n = 9'd304;
      7'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

### hw/rtl/gds_div.sv
// constant divider by reciprocal multiplication, stepping through multiply, shift and remainder
module gds_div import gds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int RECIP_W = 28;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int SH_W    = 6;
  localparam int BACK_W  = NUM_W + DEN_W;

  // reciprocals rounded up, exact floor division for any 27-bit dividend
  localparam logic [RECIP_W-1:0] RECIP_YEAR = 28'd219902326;  // 2^41 / 10000
  localparam logic [SH_W-1:0]    SHIFT_YEAR = 6'd41;
  localparam logic [RECIP_W-1:0] RECIP_QUAD = 28'd171798692;  // 2^36 / 400
  localparam logic [SH_W-1:0]    SHIFT_QUAD = 6'd36;
  localparam logic [RECIP_W-1:0] RECIP_HUND = 28'd171798692;  // 2^34 / 100
  localparam logic [SH_W-1:0]    SHIFT_HUND = 6'd34;

  localparam logic [1:0] ST_MUL   = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_REM   = 2'd2;

  logic               busy_r;
  logic               done_r;
  logic [1:0]         step_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [RECIP_W-1:0] recip_r;
  logic [SH_W-1:0]    sh_r;
  logic [PROD_W-1:0]  prod_r;
  logic [NUM_W-1:0]   quo_r;
  logic [DEN_W-1:0]   rem_r;

  logic [RECIP_W-1:0] recip_sel;
  logic [SH_W-1:0]    sh_sel;
  logic [NUM_W-1:0]   quo_nxt;
  logic [BACK_W-1:0]  back_nxt;
  logic [DEN_W-1:0]   rem_nxt;

  always_comb begin
    // any other divisor is taken as 100
    case (req.divisor)
      DIV_YEAR: begin
        recip_sel = RECIP_YEAR;
        sh_sel    = SHIFT_YEAR;
      end
      DIV_QUAD: begin
        recip_sel = RECIP_QUAD;
        sh_sel    = SHIFT_QUAD;
      end
      default: begin
        recip_sel = RECIP_HUND;
        sh_sel    = SHIFT_HUND;
      end
    endcase
    quo_nxt  = NUM_W'(prod_r >> sh_r);
    back_nxt = BACK_W'(quo_r) * BACK_W'(den_r);
    rem_nxt  = DEN_W'(BACK_W'(num_r) - back_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= ST_MUL;
    end else begin
      done_r <= busy_r && !req.start && (step_r == ST_REM);
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= ST_MUL;
      end else if (busy_r) begin
        case (step_r)
          ST_MUL:   step_r <= ST_SHIFT;
          ST_SHIFT: step_r <= ST_REM;
          default: begin
            busy_r <= 1'b0;
            step_r <= ST_MUL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r   <= req.dividend;
      den_r   <= req.divisor;
      recip_r <= recip_sel;
      sh_r    <= sh_sel;
    end else if (busy_r) begin
      case (step_r)
        ST_MUL:   prod_r <= PROD_W'(num_r) * PROD_W'(recip_r);
        ST_SHIFT: quo_r  <= quo_nxt;
        default:  rem_r  <= rem_nxt;
      endcase
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

### hw/rtl/gregorian_day_span.sv
// inclusive day count between two packed decimal gregorian dates
//
// Each input item carries two dates packed as decimal YYYYMMDD, in either
// order. The result item gives the number of days from the earlier to the
// later date with both ends counted, or date_error with a count of 0 when
// either date has a bad month or day. Spans beyond 22 bits saturate.
// Channels use valid/stall: an item moves on a rising edge with valid high
// and stall low. in_stall is high from the edge that takes an item until
// its result has been loaded into the output register.
// Each date is decoded by four passes through one shared constant divider
// (by 10000, 100, 100 and 400), followed by the S_MUL and S_ADD states that
// form the day number. One item is in flight at a time; a new item is taken
// once the result of the last has been loaded. A finished result waits in the
// output register while out_stall is high; the next item can be accepted
// during that wait, but its result is held back until the register empties.
// Synchronous active-low reset empties the output register and returns the
// sequencer to idle; no clearing pass is needed.
module gregorian_day_span import gds_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NUM_W-1:0]    in_first_date,
  input  logic [NUM_W-1:0]    in_second_date,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CNT_W-1:0]    out_day_count,
  output logic                out_date_error
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVST = 3'd1;
  localparam logic [2:0] S_DIVW  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [1:0] PH_YEAR  = 2'd0;
  localparam logic [1:0] PH_MONTH = 2'd1;
  localparam logic [1:0] PH_CENT  = 2'd2;
  localparam logic [1:0] PH_QUAD  = 2'd3;

  localparam int EXT_W = 13;

  logic [2:0]        state_r;
  logic [1:0]        phase_r;
  logic              sel_r;
  logic [NUM_W-1:0]  a_r, b_r;
  logic [YEAR_W-1:0] y_r;
  logic [DEN_W-1:0]  tmp_r;
  logic [MON_W-1:0]  m_r;
  logic [DAY_W-1:0]  d_r;
  logic [7:0]        q100_r;
  logic [6:0]        r100_r;
  logic [5:0]        q400_r;
  logic [8:0]        r400_r;
  logic [DNUM_W-1:0] mul_r;
  logic [EXT_W-1:0]  extra_r;
  logic              err_r;
  logic [DNUM_W-1:0] n1_r, n2_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_err_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_take;
  logic              out_take;
  logic              out_free;
  logic              leap;
  logic [4:0]        len;
  logic              date_ok;
  logic [EXT_W-1:0]  ceil4, ceil100, ceil400;
  logic [EXT_W-1:0]  extra_nxt;
  logic [DNUM_W-1:0] mul_nxt;
  logic [DNUM_W-1:0] n_nxt;
  logic [DNUM_W:0]   span;
  logic [CNT_W-1:0]  count_nxt;
  logic [YEAR_W:0]   y_plus3;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  gds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_req.start    = (state_r == S_DIVST);
    div_req.dividend = sel_r ? b_r : a_r;
    div_req.divisor  = DIV_YEAR;
    case (phase_r)
      PH_YEAR: begin
        div_req.dividend = sel_r ? b_r : a_r;
        div_req.divisor  = DIV_YEAR;
      end
      PH_MONTH: begin
        div_req.dividend = NUM_W'(tmp_r);
        div_req.divisor  = DIV_MONTH;
      end
      PH_CENT: begin
        div_req.dividend = NUM_W'(y_r);
        div_req.divisor  = DIV_CENT;
      end
      PH_QUAD: begin
        div_req.dividend = NUM_W'(y_r);
        div_req.divisor  = DIV_QUAD;
      end
      default: begin
        div_req.dividend = sel_r ? b_r : a_r;
        div_req.divisor  = DIV_YEAR;
      end
    endcase
  end

  // leap test and day number pieces from the decoded date
  always_comb begin
    leap      = ((y_r[1:0] == 2'd0) && (r100_r != 7'd0)) || (r400_r == 9'd0);
    len       = month_len(m_r, leap);
    date_ok   = (len != 5'd0) && (d_r != 7'd0) && (d_r <= DAY_W'(len));
    y_plus3   = {1'b0, y_r} + (YEAR_W+1)'(3);
    ceil4     = EXT_W'(y_plus3 >> 2);
    ceil100   = EXT_W'(q100_r) + EXT_W'(r100_r != 7'd0);
    ceil400   = EXT_W'(q400_r) + EXT_W'(r400_r != 9'd0);
    extra_nxt = ceil4 - ceil100 + ceil400 + EXT_W'(days_before(m_r))
              + EXT_W'(leap && (m_r > 7'd2)) + EXT_W'(d_r) - EXT_W'(1);
    mul_nxt   = DNUM_W'(y_r) * DNUM_W'(DAYS_PER_YEAR);
    n_nxt     = mul_r + DNUM_W'(extra_r);
  end

  always_comb begin
    span = {1'b0, n2_r} - {1'b0, n1_r} + (DNUM_W+1)'(1);
    if (err_r) begin
      count_nxt = '0;
    end else if (n2_r < n1_r) begin
      count_nxt = CNT_W'(1);
    end else if (span > (DNUM_W+1)'(COUNT_MAX)) begin
      count_nxt = COUNT_MAX;
    end else begin
      count_nxt = span[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_DIVST;
          end
        end
        S_DIVST: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) begin
            state_r <= (phase_r == PH_QUAD) ? S_MUL : S_DIVST;
          end
        end
        S_MUL: state_r <= S_ADD;
        S_ADD: state_r <= sel_r ? S_FIN : S_DIVST;
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          // numerically smaller packed date goes first
          if (in_first_date > in_second_date) begin
            a_r <= in_second_date;
            b_r <= in_first_date;
          end else begin
            a_r <= in_first_date;
            b_r <= in_second_date;
          end
          phase_r <= PH_YEAR;
          sel_r   <= 1'b0;
          err_r   <= 1'b0;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          case (phase_r)
            PH_YEAR: begin
              y_r   <= div_rsp.quotient[YEAR_W-1:0];
              tmp_r <= div_rsp.remainder;
            end
            PH_MONTH: begin
              m_r <= div_rsp.quotient[MON_W-1:0];
              d_r <= div_rsp.remainder[DAY_W-1:0];
            end
            PH_CENT: begin
              q100_r <= div_rsp.quotient[7:0];
              r100_r <= div_rsp.remainder[6:0];
            end
            PH_QUAD: begin
              q400_r <= div_rsp.quotient[5:0];
              r400_r <= div_rsp.remainder[8:0];
            end
            default: ;
          endcase
          phase_r <= phase_r + 2'd1;
        end
      end
      S_MUL: begin
        mul_r   <= mul_nxt;
        extra_r <= extra_nxt;
        err_r   <= err_r || !date_ok;
      end
      S_ADD: begin
        if (sel_r) begin
          n2_r <= n_nxt;
        end else begin
          n1_r <= n_nxt;
        end
        sel_r   <= 1'b1;
        phase_r <= PH_YEAR;
      end
      S_FIN: begin
        if (out_free) begin
          out_count_r <= count_nxt;
          out_err_r   <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_day_count  = out_count_r;
  assign out_date_error = out_err_r;

  // a taken item keeps the input side closed on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input not stalled after item taken");

  // divider finishes only while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVW))
    else $error("divider done outside wait state");

  // a flagged result carries no count, a clean one at least one day
  a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_err_r == (out_count_r == '0)))
    else $error("error flag and day count disagree");

  // a new result is only loaded into an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid_r && out_stall |=> out_valid_r && $stable(out_count_r))
    else $error("pending result overwritten");

endmodule
